// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the fader RTL.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RLF_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("rlf check failed");
`define RLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rlf check failed");
`define RLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rlf check failed");
`else
`define RLF_ASSERT(lbl, clk, rstn, expr)
`define RLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/rlf_pkg.sv -----
// Package of the RGB linear fader: command codes, sequencer states, widths.
// No dependencies.
`default_nettype none
package rlf_pkg;
    localparam int NUM_CH    = 3;
    localparam int FRAC_BITS = 7;
    localparam int LVL_W     = 16;
    localparam int COL_W     = 8;
    localparam int DIV_BITS  = 17;
    localparam int CNT_W     = $clog2(DIV_BITS);
    localparam int CH_W      = $clog2(NUM_CH);

    typedef enum logic [1:0] {
        K_SET  = 2'd0,
        K_FADE = 2'd1,
        K_STOP = 2'd2,
        K_TICK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- hdl/rgb_linear_fader_top.sv -----
// RGB linear fader: Q8.7 level and increment per channel, shared serial divider.
// Depends on rlf_pkg and assert_macros.svh.
//
// Usage:
//  Command words enter on i_in_valid / o_in_stall with i_kind, the colour and
//  i_fade_steps. Result words leave on o_out_valid / i_out_stall carrying the
//  pixel address and the three drive values. Set, fade and tick give one word;
//  stop gives none. i_cfg_we writes the pixel address register.
//  Set, stop and tick finish in the accept cycle; the result word is valid in
//  the next cycle, and a new word may follow then unless the output stalls.
//  A fade runs one restoring divider, one quotient bit per cycle, 17 bits per
//  channel, through three channels in turn (S_LOAD, S_DIV), then S_DONE; from
//  accept to result word o_in_stall is high.
//  One output register holds the result; while it is full and the receiver
//  stalls, o_in_stall is high and no command is taken.
//  Reset clears levels, increments, pixel address and the output valid.
`default_nettype none
`include "assert_macros.svh"
module rgb_linear_fader_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [15:0]               i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_kind,
    input  wire logic [rlf_pkg::COL_W-1:0] i_red_in,
    input  wire logic [rlf_pkg::COL_W-1:0] i_green_in,
    input  wire logic [rlf_pkg::COL_W-1:0] i_blue_in,
    input  wire logic [7:0]                i_fade_steps,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [15:0]                    o_pixel_addr,
    output logic [rlf_pkg::COL_W-1:0]      o_red_out,
    output logic [rlf_pkg::COL_W-1:0]      o_green_out,
    output logic [rlf_pkg::COL_W-1:0]      o_blue_out
);
    import rlf_pkg::*;

    t_state                 r_state, n_state;
    logic [LVL_W-1:0]       r_level [NUM_CH];
    logic [LVL_W-1:0]       n_level [NUM_CH];
    logic [LVL_W-1:0]       r_inc   [NUM_CH];
    logic [LVL_W-1:0]       n_inc   [NUM_CH];
    logic [COL_W-1:0]       r_colour [NUM_CH];
    logic [COL_W-1:0]       n_colour [NUM_CH];
    logic [7:0]             r_steps, n_steps;
    logic [CH_W-1:0]        r_ch, n_ch;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIV_BITS-1:0]    r_quo, n_quo;
    logic [7:0]             r_rem, n_rem;
    logic                   r_neg, n_neg;
    logic [15:0]            r_pixel_index, n_pixel_index;
    logic                   r_out_valid, n_out_valid;
    logic [15:0]            r_addr, n_addr;
    logic [COL_W-1:0]       r_out_col [NUM_CH];
    logic [COL_W-1:0]       n_out_col [NUM_CH];

    logic                   out_free;
    logic                   in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        logic [COL_W-1:0]    col_in [NUM_CH];
        logic [LVL_W-1:0]    lvl_sum [NUM_CH];
        logic [LVL_W+1:0]    diff;
        logic [LVL_W+1:0]    diff_abs;
        logic [LVL_W-1:0]    cur_lvl;
        logic [8:0]          rem_sh;
        logic [8:0]          rem_sub;
        logic                geq;
        logic [DIV_BITS-1:0] quo_step;
        logic [DIV_BITS-1:0] quo_sgn;
        logic                emit;

        col_in[0] = i_red_in;
        col_in[1] = i_green_in;
        col_in[2] = i_blue_in;
        for (int c = 0; c < NUM_CH; c++) begin
            lvl_sum[c] = r_level[c] + r_inc[c];
        end

        cur_lvl  = r_level[r_ch];
        diff     = {3'b000, r_colour[r_ch], {FRAC_BITS{1'b0}}}
                   - {{2{cur_lvl[LVL_W-1]}}, cur_lvl};
        diff_abs = diff[LVL_W+1] ? (~diff + 1'b1) : diff;

        rem_sh   = {r_rem, r_quo[DIV_BITS-1]};
        rem_sub  = rem_sh - {1'b0, r_steps};
        geq      = rem_sh >= {1'b0, r_steps};
        quo_step = {r_quo[DIV_BITS-2:0], geq};
        quo_sgn  = r_neg ? (~quo_step + 1'b1) : quo_step;

        n_state       = r_state;
        n_level       = r_level;
        n_inc         = r_inc;
        n_colour      = r_colour;
        n_steps       = r_steps;
        n_ch          = r_ch;
        n_cnt         = r_cnt;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_neg         = r_neg;
        n_pixel_index = i_cfg_we ? i_cfg_wdata : r_pixel_index;
        n_out_valid   = r_out_valid && i_out_stall;
        n_addr        = r_addr;
        n_out_col     = r_out_col;
        emit          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_kind'(i_kind))
                        K_SET: begin
                            for (int c = 0; c < NUM_CH; c++) begin
                                n_level[c] = {1'b0, col_in[c], {FRAC_BITS{1'b0}}};
                                n_inc[c]   = '0;
                            end
                            emit = 1'b1;
                        end
                        K_FADE: begin
                            n_colour = col_in;
                            n_steps  = (i_fade_steps == 8'd0) ? 8'd1 : i_fade_steps;
                            n_ch     = '0;
                            n_state  = S_LOAD;
                        end
                        K_STOP: begin
                            for (int c = 0; c < NUM_CH; c++) begin
                                n_inc[c] = '0;
                            end
                        end
                        K_TICK: begin
                            n_level = lvl_sum;
                            emit    = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                n_neg   = diff[LVL_W+1];
                n_quo   = diff_abs[DIV_BITS-1:0];
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = geq ? rem_sub[7:0] : rem_sh[7:0];
                n_quo = quo_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_inc[r_ch] = quo_sgn[LVL_W-1:0];
                    if (r_ch == CH_W'(NUM_CH - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_DONE: begin
                n_level = lvl_sum;
                emit    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_addr      = r_pixel_index;
            for (int c = 0; c < NUM_CH; c++) begin
                n_out_col[c] = n_level[c][FRAC_BITS +: COL_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_pixel_index <= '0;
            r_ch          <= '0;
            r_cnt         <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_level[c] <= '0;
                r_inc[c]   <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_pixel_index <= n_pixel_index;
            r_ch          <= n_ch;
            r_cnt         <= n_cnt;
            r_level       <= n_level;
            r_inc         <= n_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_colour  <= n_colour;
        r_steps   <= n_steps;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_addr    <= n_addr;
        r_out_col <= n_out_col;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_addr = r_addr;
    assign o_red_out    = r_out_col[0];
    assign o_green_out  = r_out_col[1];
    assign o_blue_out   = r_out_col[2];

    `RLF_ASSERT_NEXT(a_fade_starts, i_clk, i_rst_n, in_acc && (i_kind == K_FADE), r_state == S_LOAD)
    `RLF_ASSERT_IMPL(a_done_slot_free, i_clk, i_rst_n, r_state == S_DONE, !r_out_valid)
    `RLF_ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `RLF_ASSERT(a_ch_range, i_clk, i_rst_n, r_ch <= CH_W'(NUM_CH - 1))
endmodule
`default_nettype wire
